// File: src/ipa_pkg.sv
// ipa_pkg: shared constants, types and the hex digit decoder for the IPv6 text parser
// no dependencies; used by ipa_scan, ipa_assemble and ipv6_text_address_parser
`timescale 1ns / 1ps

package ipa_pkg;

  localparam int Groups     = 8;
  localparam int GroupWidth = 16;
  localparam int CountWidth = 4;
  localparam int CharWidth  = 8;
  localparam int HalfWidth  = 64;

  localparam logic [CharWidth-1:0] CharColon = 8'h3A;

  typedef logic [Groups-1:0][GroupWidth-1:0] group_vec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // parse state after the final character, handed to the assembler
  typedef struct packed {
    logic                  err;
    logic [CountWidth-1:0] count;
    logic [CountWidth-1:0] gap_pos;
    group_vec_t            head;
    group_vec_t            tail;
  } fin_t;

  function automatic hex_t hex_decode(input logic [CharWidth-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: src/ipa_scan.sv
// ipa_scan: per-character parse state and the group registers
// depends on ipa_pkg; feeds the final parse state to ipa_assemble
`timescale 1ns / 1ps

module ipa_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [ipa_pkg::CharWidth-1:0]    char_code,
  input  logic                             last_char,
  output ipa_pkg::fin_t                    fin
);

  // groups before the gap sit at their index, groups after it shift in from the bottom
  ipa_pkg::group_vec_t                   head;
  ipa_pkg::group_vec_t                   tail;
  logic [ipa_pkg::CountWidth-1:0]        count;
  logic [ipa_pkg::GroupWidth-1:0]        accum;
  logic                                  digit_seen;
  logic [ipa_pkg::CountWidth-1:0]        gap_pos;
  logic                                  gap_seen;
  logic                                  prev_colon;
  logic                                  err_latched;

  ipa_pkg::group_vec_t                   head_next;
  ipa_pkg::group_vec_t                   tail_next;
  logic [ipa_pkg::CountWidth-1:0]        count_next;
  logic [ipa_pkg::GroupWidth-1:0]        accum_next;
  logic                                  digit_seen_next;
  logic [ipa_pkg::CountWidth-1:0]        gap_pos_next;
  logic                                  gap_seen_next;
  logic                                  prev_colon_next;
  logic                                  err_next;
  ipa_pkg::hex_t                         hx;
  logic [ipa_pkg::CountWidth-1:0]        fin_count;
  logic                                  fin_err;

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    accum_next      = accum;
    digit_seen_next = digit_seen;
    gap_pos_next    = gap_pos;
    gap_seen_next   = gap_seen;
    prev_colon_next = prev_colon;
    err_next        = err_latched;
    hx              = ipa_pkg::hex_decode(char_code);
    if (!err_latched) begin
      if (char_code == ipa_pkg::CharColon) begin
        if (digit_seen) begin
          if (count >= 4'(ipa_pkg::Groups - 1)) begin
            err_next = 1'b1;
          end else begin
            if (gap_seen) begin
              tail_next = {tail[ipa_pkg::Groups-2:0], accum};
            end else begin
              head_next[count[2:0]] = accum;
            end
            count_next      = count + 4'd1;
            accum_next      = '0;
            digit_seen_next = 1'b0;
            prev_colon_next = 1'b1;
          end
        end else if (prev_colon) begin
          if (gap_seen) begin
            err_next = 1'b1;
          end else begin
            gap_seen_next = 1'b1;
            gap_pos_next  = count;
          end
        end else begin
          prev_colon_next = 1'b1;
        end
      end else if (!hx.ok) begin
        err_next = 1'b1;
      end else if (prev_colon && count == '0 && !gap_seen) begin
        // single leading colon followed by a digit
        err_next = 1'b1;
      end else if (digit_seen) begin
        if (accum[15:12] != 4'd0) begin
          err_next = 1'b1;
        end else begin
          accum_next      = {accum[11:0], hx.val};
          prev_colon_next = 1'b0;
        end
      end else begin
        accum_next      = {12'd0, hx.val};
        digit_seen_next = 1'b1;
        prev_colon_next = 1'b0;
      end
    end
  end

  // end of string: close the open group and check the group count
  always_comb begin
    fin.head  = head_next;
    fin.tail  = tail_next;
    fin_count = count_next;
    fin_err   = err_next;
    if (!err_next) begin
      if (digit_seen_next) begin
        if (count_next >= 4'(ipa_pkg::Groups)) begin
          fin_err = 1'b1;
        end else begin
          if (gap_seen_next) begin
            fin.tail = {tail_next[ipa_pkg::Groups-2:0], accum_next};
          end else begin
            fin.head[count_next[2:0]] = accum_next;
          end
          fin_count = count_next + 4'd1;
        end
      end else if (!(prev_colon_next && gap_seen_next && gap_pos_next == count_next)) begin
        fin_err = 1'b1;
      end
    end
    if (!fin_err) begin
      if (gap_seen_next) begin
        if (fin_count > 4'(ipa_pkg::Groups - 1)) fin_err = 1'b1;
      end else if (fin_count != 4'(ipa_pkg::Groups)) begin
        fin_err = 1'b1;
      end
    end
    fin.err     = fin_err;
    fin.count   = fin_count;
    fin.gap_pos = gap_seen_next ? gap_pos_next : fin_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      accum       <= '0;
      digit_seen  <= 1'b0;
      gap_pos     <= '0;
      gap_seen    <= 1'b0;
      prev_colon  <= 1'b0;
      err_latched <= 1'b0;
    end else if (step) begin
      if (last_char) begin
        count       <= '0;
        accum       <= '0;
        digit_seen  <= 1'b0;
        gap_pos     <= '0;
        gap_seen    <= 1'b0;
        prev_colon  <= 1'b0;
        err_latched <= 1'b0;
      end else begin
        count       <= count_next;
        accum       <= accum_next;
        digit_seen  <= digit_seen_next;
        gap_pos     <= gap_pos_next;
        gap_seen    <= gap_seen_next;
        prev_colon  <= prev_colon_next;
        err_latched <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !last_char) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

endmodule

// File: src/ipa_assemble.sv
// ipa_assemble: expands the parsed groups around the gap into the 128-bit address
// depends on ipa_pkg; driven by ipa_scan
`timescale 1ns / 1ps

module ipa_assemble (
  input  ipa_pkg::fin_t                    fin,
  output logic [ipa_pkg::HalfWidth-1:0]    addr_high,
  output logic [ipa_pkg::HalfWidth-1:0]    addr_low,
  output logic                             parse_error
);

  ipa_pkg::group_vec_t              g;
  logic [ipa_pkg::CountWidth-1:0]   tail_count;

  assign tail_count = fin.count - fin.gap_pos;

  always_comb begin
    for (int i = 0; i < ipa_pkg::Groups; i++) begin
      g[ipa_pkg::Groups-1-i] = '0;
      if (4'(i) < fin.gap_pos) begin
        g[ipa_pkg::Groups-1-i] = fin.head[i];
      end else if (4'(ipa_pkg::Groups - 1 - i) < tail_count) begin
        // tail entry zero is the last group of the address
        g[ipa_pkg::Groups-1-i] = fin.tail[ipa_pkg::Groups-1-i];
      end
    end
  end

  // g is packed with group 0 in the top slice
  assign addr_high   = fin.err ? '0 : g[7:4];
  assign addr_low    = fin.err ? '0 : g[3:0];
  assign parse_error = fin.err;

endmodule

// File: src/ipv6_text_address_parser.sv
// ipv6_text_address_parser: top level, input register, parse logic and result register
// depends on ipa_pkg, ipa_scan and ipa_assemble
`timescale 1ns / 1ps

// Usage
//   request channel: char_valid/char_ready carry one ASCII character of an IPv6
//   address per request in char_code, with last_char high on the final one.
//   result channel: addr_valid/addr_ready carry one result per string: the
//   address as addr_high (groups 0 to 3) and addr_low (groups 4 to 7), and
//   parse_error, which forces both halves to zero.
//   Order: a final character is first captured in the input register, then its
//   result is registered in the result register, which raises addr_valid.
//   Throughput: one character per cycle, but a final character holds while a
//   result waits on addr_ready.
//   Stall: while a result waits on addr_ready, characters that are not final
//   still flow; a final character holds in the input register until the
//   result register is free.
//   Reset: rst is synchronous; it empties both registers and returns the
//   parser to the start of a string.
//   After every final character the parser starts a fresh string.

module ipv6_text_address_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             char_valid,
  output logic                             char_ready,
  input  logic [ipa_pkg::CharWidth-1:0]    char_code,
  input  logic                             last_char,
  output logic                             addr_valid,
  input  logic                             addr_ready,
  output logic [ipa_pkg::HalfWidth-1:0]    addr_high,
  output logic [ipa_pkg::HalfWidth-1:0]    addr_low,
  output logic                             parse_error
);

  logic                             s1_valid;
  logic [ipa_pkg::CharWidth-1:0]    s1_char;
  logic                             s1_last;
  logic                             adv;
  ipa_pkg::fin_t                    fin;
  logic [ipa_pkg::HalfWidth-1:0]    res_high;
  logic [ipa_pkg::HalfWidth-1:0]    res_low;
  logic                             res_err;

  assign adv        = s1_valid && (!s1_last || !addr_valid || addr_ready);
  assign char_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_valid && char_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  ipa_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .char_code (s1_char),
    .last_char (s1_last),
    .fin       (fin)
  );

  ipa_assemble u_assemble (
    .fin         (fin),
    .addr_high   (res_high),
    .addr_low    (res_low),
    .parse_error (res_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (adv && s1_last) begin
      addr_valid <= 1'b1;
    end else if (addr_ready) begin
      addr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      addr_high   <= res_high;
      addr_low    <= res_low;
      parse_error <= res_err;
    end
  end

endmodule

// File: src/ipa_checker.sv
// ipa_checker: port-level assertions for ipv6_text_address_parser
// depends only on the top-level ports; attached by the bind below
`timescale 1ns / 1ps

module ipa_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_ready,
  input logic        addr_valid,
  input logic        addr_ready,
  input logic [63:0] addr_high,
  input logic [63:0] addr_low,
  input logic        parse_error
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !addr_valid)
    else $error("result valid after reset");

  // with the result register free the block always takes a request
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !addr_valid |-> char_ready)
    else $error("request stalled with empty result register");

  // a malformed string reports an all-zero address
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    addr_valid && parse_error |-> addr_high == 64'd0 && addr_low == 64'd0)
    else $error("nonzero address with parse error");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    addr_valid && !addr_ready |=> addr_valid && $stable(addr_high) && $stable(addr_low)
      && $stable(parse_error))
    else $error("stalled result changed");

endmodule

bind ipv6_text_address_parser ipa_checker u_ipa_checker (
  .clk         (clk),
  .rst         (rst),
  .char_ready  (char_ready),
  .addr_valid  (addr_valid),
  .addr_ready  (addr_ready),
  .addr_high   (addr_high),
  .addr_low    (addr_low),
  .parse_error (parse_error)
);
